// ===== src/sfs_pkg.sv =====
// sfs_pkg: widths, register codes, shared structs and helpers of the sprite frame sequencer
// no dependencies; compile first
package sfs_pkg;

    localparam int TIME_W      = 16;
    localparam int FRAME_W     = 8;
    localparam int COORD_W     = 16;
    localparam int PERIOD_W    = 16;
    localparam int COUNT_W     = 9;
    localparam int DIM_W       = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int ACC_W       = 17;
    localparam int DIV_W       = 17;
    localparam int DVS_W       = 16;
    localparam int PROD_W      = FRAME_W + DIM_W;
    localparam int SUM_W       = PROD_W + 1;

    localparam int MAX_FRAMES_DEF = 256;
    localparam int TIME_BITS_DEF  = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PERIOD = 3'd0,
        REG_START  = 3'd1,
        REG_COUNT  = 3'd2,
        REG_FPR    = 3'd3,
        REG_WIDTH  = 3'd4,
        REG_HEIGHT = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [FRAME_W-1:0]  first;
        logic [FRAME_W-1:0]  last;
        logic [COUNT_W-1:0]  len;
        logic [COUNT_W-1:0]  fpr;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DVS_W-1:0] rem;
    } div_rsp_t;

    function automatic logic [COORD_W-1:0] sat16(input logic [SUM_W-1:0] v);
        logic [COORD_W-1:0] r;
        if (v > SUM_W'({COORD_W{1'b1}}))
        begin
            r = '1;
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== src/sfs_if.sv =====
// sfs_if: valid/ready channels for tick requests and frame results
// depends on sfs_pkg
interface sfs_tick_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [sfs_pkg::TIME_W-1:0] delta_ticks;

    modport source (output valid, op, delta_ticks, input ready);
    modport sink   (input valid, op, delta_ticks, output ready);
endinterface

interface sfs_frame_if;
    logic                        valid;
    logic                        ready;
    logic [sfs_pkg::FRAME_W-1:0] frame_index;
    logic [sfs_pkg::COORD_W-1:0] src_left;
    logic [sfs_pkg::COORD_W-1:0] src_top;
    logic [sfs_pkg::COORD_W-1:0] src_right;
    logic [sfs_pkg::COORD_W-1:0] src_bottom;

    modport source (output valid, frame_index, src_left, src_top, src_right, src_bottom,
                    input ready);
    modport sink   (input valid, frame_index, src_left, src_top, src_right, src_bottom,
                    output ready);
endinterface

// ===== src/sfs_div.sv =====
// sfs_div: shared restoring divider, one quotient bit per cycle
// depends on sfs_pkg
module sfs_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  sfs_pkg::div_req_t req,
    output sfs_pkg::div_rsp_t rsp
);
    localparam int CNT_W = $clog2(sfs_pkg::DIV_W);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [sfs_pkg::DVS_W-1:0] rem_reg, rem_next;
    logic [sfs_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [sfs_pkg::DVS_W-1:0] dvs_reg, dvs_next;
    logic [sfs_pkg::DVS_W:0]   r_sh;
    logic                      ge;

    assign r_sh = {rem_reg, quo_reg[sfs_pkg::DIV_W-1]};
    assign ge   = r_sh >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? sfs_pkg::DVS_W'(r_sh - {1'b0, dvs_reg}) : r_sh[sfs_pkg::DVS_W-1:0];
            quo_next = {quo_reg[sfs_pkg::DIV_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(sfs_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== src/sfs_cfg.sv =====
// sfs_cfg: configuration registers and the sequence bounds derived from them
// depends on sfs_pkg
module sfs_cfg
#(
    parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           we,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]  index,
    input  logic [sfs_pkg::CFG_DATA_W-1:0] data,
    output sfs_pkg::cfg_t                  cfg
);
    localparam int LAST_I = ((MAX_FRAMES < 256) ? MAX_FRAMES : 256) - 1;
    localparam logic [sfs_pkg::FRAME_W-1:0] LAST = sfs_pkg::FRAME_W'(LAST_I);

    logic [sfs_pkg::PERIOD_W-1:0] period_reg;
    logic [sfs_pkg::FRAME_W-1:0]  start_reg;
    logic [sfs_pkg::COUNT_W-1:0]  count_reg;
    logic [sfs_pkg::COUNT_W-1:0]  fpr_reg;
    logic [sfs_pkg::DIM_W-1:0]    width_reg;
    logic [sfs_pkg::DIM_W-1:0]    height_reg;

    logic [sfs_pkg::COUNT_W-1:0]  cnt;
    logic [sfs_pkg::COUNT_W:0]    end_raw;
    logic [sfs_pkg::FRAME_W-1:0]  s;
    logic [sfs_pkg::FRAME_W-1:0]  e_clip;
    logic [sfs_pkg::FRAME_W-1:0]  e;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= sfs_pkg::PERIOD_W'(1);
            start_reg  <= '0;
            count_reg  <= sfs_pkg::COUNT_W'(1);
            fpr_reg    <= sfs_pkg::COUNT_W'(1);
            width_reg  <= '0;
            height_reg <= '0;
        end
        else if (we)
        begin
            unique case (sfs_pkg::cfg_reg_t'(index))
                sfs_pkg::REG_PERIOD: period_reg <= data[sfs_pkg::PERIOD_W-1:0];
                sfs_pkg::REG_START:  start_reg  <= data[sfs_pkg::FRAME_W-1:0];
                sfs_pkg::REG_COUNT:  count_reg  <= data[sfs_pkg::COUNT_W-1:0];
                sfs_pkg::REG_FPR:    fpr_reg    <= data[sfs_pkg::COUNT_W-1:0];
                sfs_pkg::REG_WIDTH:  width_reg  <= data[sfs_pkg::DIM_W-1:0];
                sfs_pkg::REG_HEIGHT: height_reg <= data[sfs_pkg::DIM_W-1:0];
                default:             ;
            endcase
        end
    end

    // zero count, period and frames per row behave as one
    always_comb
    begin
        cnt     = (count_reg == '0) ? sfs_pkg::COUNT_W'(1) : count_reg;
        end_raw = {2'b00, start_reg} + {1'b0, cnt} - (sfs_pkg::COUNT_W+1)'(1);
        s       = (start_reg > LAST) ? LAST : start_reg;
        e_clip  = (end_raw > {2'b00, LAST}) ? LAST : end_raw[sfs_pkg::FRAME_W-1:0];
        e       = (e_clip < s) ? s : e_clip;
    end

    assign cfg.period = (period_reg == '0) ? sfs_pkg::PERIOD_W'(1) : period_reg;
    assign cfg.first  = s;
    assign cfg.last   = e;
    assign cfg.len    = {1'b0, e} - {1'b0, s} + sfs_pkg::COUNT_W'(1);
    assign cfg.fpr    = (fpr_reg == '0) ? sfs_pkg::COUNT_W'(1) : fpr_reg;
    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;

endmodule

// ===== src/sprite_frame_sequencer.sv =====
// sprite_frame_sequencer: top level, sequencer around one shared divider and one multiplier
// depends on sfs_pkg, sfs_if, sfs_cfg, sfs_div
//
// Each tick request adds its elapsed ticks to the time accumulator (the first request after
// reset only clears it), takes off whole frame periods, steps the frame forward or backward
// within the played sequence and returns the frame index with its source rectangle in the
// sheet. One request at a time is worked on. The shared 17-bit divider takes one quotient
// bit a cycle and serves the period division, the wrap modulo and the row/column split, and
// it sets the timing. When frames step, an extra modulo division runs between the period
// division and the row/column split. A finished result sits in an output register, so the
// next request is taken while it waits. A result that is still waiting holds the following
// one until it is taken. Configuration writes go to index 0 to 5; the user must write them
// only while idle, as the block itself does not enforce it.
module sprite_frame_sequencer
#(
    parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF,
    parameter int TIME_BITS  = sfs_pkg::TIME_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfs_pkg::CFG_DATA_W-1:0] cfg_data,
    sfs_tick_if.sink                       tick,
    sfs_frame_if.source                    frame
);
    localparam logic [sfs_pkg::TIME_W-1:0] DELTA_MASK = (TIME_BITS >= sfs_pkg::TIME_W)
        ? {sfs_pkg::TIME_W{1'b1}}
        : sfs_pkg::TIME_W'((64'd1 << TIME_BITS) - 64'd1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_DIV_T = 10'b00_0000_0010,
        S_SNAP  = 10'b00_0000_0100,
        S_DIV_K = 10'b00_0000_1000,
        S_WRAP  = 10'b00_0001_0000,
        S_ROW   = 10'b00_0010_0000,
        S_DIV_R = 10'b00_0100_0000,
        S_MUL_L = 10'b00_1000_0000,
        S_MUL_T = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } state_t;

    sfs_pkg::cfg_t     cfg;
    sfs_pkg::div_req_t div_req;
    sfs_pkg::div_rsp_t div_rsp;

    state_t                        state_reg, state_next;
    logic                          first_reg, first_next;
    logic [sfs_pkg::ACC_W-1:0]     acc_reg, acc_next;
    logic [sfs_pkg::FRAME_W-1:0]   cur_reg, cur_next;
    logic [sfs_pkg::DIV_W-1:0]     n_reg, n_next;
    logic                          back_reg, back_next;
    logic [sfs_pkg::COUNT_W-1:0]   k_reg, k_next;
    logic [sfs_pkg::FRAME_W-1:0]   row_reg, row_next;
    logic [sfs_pkg::FRAME_W-1:0]   col_reg, col_next;
    logic [sfs_pkg::PROD_W-1:0]    left_reg, left_next;
    logic [sfs_pkg::PROD_W-1:0]    top_reg, top_next;
    logic                          out_valid_reg, out_valid_next;
    logic [sfs_pkg::FRAME_W-1:0]   out_index_reg, out_index_next;
    logic [sfs_pkg::COORD_W-1:0]   out_left_reg, out_left_next;
    logic [sfs_pkg::COORD_W-1:0]   out_top_reg, out_top_next;
    logic [sfs_pkg::COORD_W-1:0]   out_right_reg, out_right_next;
    logic [sfs_pkg::COORD_W-1:0]   out_bottom_reg, out_bottom_next;

    logic                          accept;
    logic [sfs_pkg::ACC_W-1:0]     acc_sum;
    logic                          in_range;
    logic [sfs_pkg::FRAME_W-1:0]   off;
    logic [sfs_pkg::COUNT_W:0]     wrap_sum;
    logic [sfs_pkg::COUNT_W:0]     wrap_mod;
    logic [sfs_pkg::FRAME_W-1:0]   mul_a;
    logic [sfs_pkg::DIM_W-1:0]     mul_b;
    logic [sfs_pkg::PROD_W-1:0]    product;
    logic [sfs_pkg::SUM_W-1:0]     right_sum;
    logic [sfs_pkg::SUM_W-1:0]     bottom_sum;

    sfs_cfg #(.MAX_FRAMES(MAX_FRAMES)) u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    sfs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign tick.ready = (state_reg == S_IDLE);
    assign accept     = tick.valid && tick.ready;
    assign acc_sum    = acc_reg + {1'b0, tick.delta_ticks & DELTA_MASK};
    assign in_range   = (cur_reg >= cfg.first) && (cur_reg <= cfg.last);
    assign off        = cur_reg - cfg.first;

    // offset within the sequence after k steps, reduced once modulo the length
    always_comb
    begin
        if (back_reg)
        begin
            wrap_sum = {2'b00, off} + {1'b0, cfg.len} - {1'b0, k_reg};
        end
        else
        begin
            wrap_sum = {2'b00, off} + {1'b0, k_reg};
        end
        wrap_mod = (wrap_sum >= {1'b0, cfg.len}) ? (wrap_sum - {1'b0, cfg.len}) : wrap_sum;
    end

    // one multiplier for left and top
    assign mul_a      = (state_reg == S_MUL_T) ? row_reg : col_reg;
    assign mul_b      = (state_reg == S_MUL_T) ? cfg.height : cfg.width;
    assign product    = {{sfs_pkg::DIM_W{1'b0}}, mul_a} * {{sfs_pkg::FRAME_W{1'b0}}, mul_b};
    assign right_sum  = {1'b0, left_reg} + sfs_pkg::SUM_W'(cfg.width);
    assign bottom_sum = {1'b0, top_reg} + sfs_pkg::SUM_W'(cfg.height);

    always_comb
    begin
        state_next       = state_reg;
        first_next       = first_reg;
        acc_next         = acc_reg;
        cur_next         = cur_reg;
        n_next           = n_reg;
        back_next        = back_reg;
        k_next           = k_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        left_next        = left_reg;
        top_next         = top_reg;
        out_valid_next   = out_valid_reg;
        out_index_next   = out_index_reg;
        out_left_next    = out_left_reg;
        out_top_next     = out_top_reg;
        out_right_next   = out_right_reg;
        out_bottom_next  = out_bottom_reg;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;

        if (out_valid_reg && frame.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    back_next = tick.op;
                    if (first_reg)
                    begin
                        first_next = 1'b0;
                        acc_next   = '0;
                    end
                    else
                    begin
                        acc_next = acc_sum;
                    end
                    div_req.start    = 1'b1;
                    div_req.dividend = first_reg ? '0 : acc_sum;
                    div_req.divisor  = cfg.period;
                    state_next       = S_DIV_T;
                end
            end
            S_DIV_T:
            begin
                if (div_rsp.done)
                begin
                    acc_next   = {1'b0, div_rsp.rem};
                    n_next     = div_rsp.quot;
                    state_next = S_SNAP;
                end
            end
            S_SNAP:
            begin
                if (n_reg == '0)
                begin
                    state_next = S_ROW;
                end
                else
                begin
                    div_req.start   = 1'b1;
                    div_req.divisor = sfs_pkg::DVS_W'(cfg.len);
                    if (in_range)
                    begin
                        div_req.dividend = n_reg;
                    end
                    else
                    begin
                        // an index outside snaps to first (forward) or last (back) first
                        cur_next         = back_reg ? cfg.last : cfg.first;
                        div_req.dividend = n_reg - sfs_pkg::DIV_W'(1);
                    end
                    state_next = S_DIV_K;
                end
            end
            S_DIV_K:
            begin
                if (div_rsp.done)
                begin
                    k_next     = div_rsp.rem[sfs_pkg::COUNT_W-1:0];
                    state_next = S_WRAP;
                end
            end
            S_WRAP:
            begin
                cur_next   = cfg.first + wrap_mod[sfs_pkg::FRAME_W-1:0];
                state_next = S_ROW;
            end
            S_ROW:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = sfs_pkg::DIV_W'(cur_reg);
                div_req.divisor  = sfs_pkg::DVS_W'(cfg.fpr);
                state_next       = S_DIV_R;
            end
            S_DIV_R:
            begin
                if (div_rsp.done)
                begin
                    row_next   = div_rsp.quot[sfs_pkg::FRAME_W-1:0];
                    col_next   = div_rsp.rem[sfs_pkg::FRAME_W-1:0];
                    state_next = S_MUL_L;
                end
            end
            S_MUL_L:
            begin
                left_next  = product;
                state_next = S_MUL_T;
            end
            S_MUL_T:
            begin
                top_next   = product;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || frame.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = cur_reg;
                    out_left_next   = sfs_pkg::sat16({1'b0, left_reg});
                    out_top_next    = sfs_pkg::sat16({1'b0, top_reg});
                    out_right_next  = sfs_pkg::sat16(right_sum);
                    out_bottom_next = sfs_pkg::sat16(bottom_sum);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            first_reg     <= 1'b1;
            acc_reg       <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            acc_reg       <= acc_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        back_reg       <= back_next;
        k_reg          <= k_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        left_reg       <= left_next;
        top_reg        <= top_next;
        out_index_reg  <= out_index_next;
        out_left_reg   <= out_left_next;
        out_top_reg    <= out_top_next;
        out_right_reg  <= out_right_next;
        out_bottom_reg <= out_bottom_next;
    end

    assign frame.valid       = out_valid_reg;
    assign frame.frame_index = out_index_reg;
    assign frame.src_left    = out_left_reg;
    assign frame.src_top     = out_top_reg;
    assign frame.src_right   = out_right_reg;
    assign frame.src_bottom  = out_bottom_reg;

    // one request at a time
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !tick.ready)
        else $error("request taken while another is in progress");

    // the accumulator keeps less than one period once the periods are taken off
    a_acc_below_period: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SNAP) |-> ({1'b0, cfg.period} > acc_reg))
        else $error("accumulator not reduced below the frame period");

    // after a wrap the frame lies inside the sequence
    a_wrap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROW) && $past(state_reg == S_WRAP) |->
            (cur_reg >= cfg.first) && (cur_reg <= cfg.last))
        else $error("frame outside the sequence after stepping");

    // divider finishes only while the sequencer waits on it
    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV_T) || (state_reg == S_DIV_K) ||
            (state_reg == S_DIV_R))
        else $error("divider result with no division pending");

endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for sprite_frame_sequencer, directed table then random phases
// depends on sfs_pkg, sfs_if and the sprite_frame_sequencer rtl
`timescale 1ns / 100ps

module tb;
    import sfs_pkg::*;

    localparam logic DIR_FWD  = 1'b0;
    localparam logic DIR_BACK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int unsigned LAST_FRAME = 255;
    localparam int unsigned SAT_MAX    = 65535;
    localparam int          PLAN_LEN   = 45;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_index;
        logic [COORD_W-1:0] src_left;
        logic [COORD_W-1:0] src_top;
        logic [COORD_W-1:0] src_right;
        logic [COORD_W-1:0] src_bottom;
    } frame_rec_t;

    typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic                   dir;
        logic [TIME_W-1:0]      dt;
        logic                   typed;
        frame_rec_t             want;
    } plan_row_t;

    localparam frame_rec_t RECT_ZERO = '0;
    localparam frame_rec_t RECT_250  = '{8'd250, 16'd0, 16'hFFFF, 16'd4095, 16'hFFFF};
    localparam frame_rec_t RECT_255  = '{8'd255, 16'd0, 16'hFFFF, 16'd4095, 16'hFFFF};

    // directed plan: expected rectangle typed in where it is obvious
    plan_row_t plan [PLAN_LEN] = '{
        '{ROW_TICK,  '0,           16'h0000, DIR_FWD,  16'hFFFF, 1'b1, RECT_ZERO},
        '{ROW_TICK,  '0,           16'h0000, DIR_FWD,  16'h0000, 1'b1, RECT_ZERO},
        '{ROW_TICK,  '0,           16'h0000, DIR_BACK, 16'hFFFF, 1'b1, RECT_ZERO},
        '{ROW_WRITE, REG_PERIOD,   16'h0000, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_WRITE, REG_START,    16'h00FA, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_WRITE, REG_COUNT,    16'h0014, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_WRITE, REG_FPR,      16'h0000, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_WRITE, REG_WIDTH,    16'h0FFF, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_WRITE, REG_HEIGHT,   16'h0FFF, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_WRITE, REG_SPARE_LO, 16'hFFFF, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_WRITE, REG_SPARE_HI, 16'hFFFF, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_TICK,  '0,           16'h0000, DIR_FWD,  16'h0001, 1'b1, RECT_250},
        '{ROW_TICK,  '0,           16'h0000, DIR_BACK, 16'h0001, 1'b1, RECT_255},
        '{ROW_TICK,  '0,           16'h0000, DIR_FWD,  16'h0001, 1'b1, RECT_250},
        '{ROW_TICK,  '0,           16'h0000, DIR_FWD,  16'hFFFF, 1'b0, RECT_ZERO},
        '{ROW_WRITE, REG_PERIOD,   16'hFFFF, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_WRITE, REG_START,    16'h0000, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_WRITE, REG_COUNT,    16'h0100, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_WRITE, REG_FPR,      16'h0100, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_WRITE, REG_WIDTH,    16'h0FFF, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_WRITE, REG_HEIGHT,   16'h0000, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_TICK,  '0,           16'h0000, DIR_FWD,  16'hFFFE, 1'b0, RECT_ZERO},
        '{ROW_TICK,  '0,           16'h0000, DIR_FWD,  16'hFFFF, 1'b0, RECT_ZERO},
        '{ROW_TICK,  '0,           16'h0000, DIR_BACK, 16'h0001, 1'b0, RECT_ZERO},
        '{ROW_WRITE, REG_PERIOD,   16'h0003, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_WRITE, REG_START,    16'h000A, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_WRITE, REG_COUNT,    16'h0000, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_WRITE, REG_FPR,      16'h0010, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_WRITE, REG_WIDTH,    16'h0064, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_WRITE, REG_HEIGHT,   16'h0032, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_TICK,  '0,           16'h0000, DIR_FWD,  16'h0002, 1'b0, RECT_ZERO},
        '{ROW_TICK,  '0,           16'h0000, DIR_FWD,  16'h0001, 1'b0, RECT_ZERO},
        '{ROW_TICK,  '0,           16'h0000, DIR_BACK, 16'h0009, 1'b0, RECT_ZERO},
        '{ROW_WRITE, REG_PERIOD,   16'h0002, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_WRITE, REG_START,    16'hA505, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_WRITE, REG_COUNT,    16'hFE09, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_WRITE, REG_FPR,      16'hAA04, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_WRITE, REG_WIDTH,    16'hF12C, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_WRITE, REG_HEIGHT,   16'h70C8, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO},
        '{ROW_TICK,  '0,           16'h0000, DIR_FWD,  16'h0001, 1'b0, RECT_ZERO},
        '{ROW_TICK,  '0,           16'h0000, DIR_FWD,  16'h0001, 1'b0, RECT_ZERO},
        '{ROW_TICK,  '0,           16'h0000, DIR_BACK, 16'h0007, 1'b0, RECT_ZERO},
        '{ROW_TICK,  '0,           16'h0000, DIR_FWD,  16'd40000, 1'b0, RECT_ZERO},
        '{ROW_TICK,  '0,           16'h0000, DIR_BACK, 16'hFFFF, 1'b0, RECT_ZERO},
        '{ROW_TICK,  '0,           16'h0000, DIR_FWD,  16'h0000, 1'b0, RECT_ZERO}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sfs_tick_if  tick_ch ();
    sfs_frame_if frame_ch ();

    sprite_frame_sequencer u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick_ch),
        .frame     (frame_ch)
    );

    // animation state and register copies
    logic [ACC_W-1:0]    acc_ticks;
    logic                awaiting_first;
    logic [FRAME_W-1:0]  cur_frame;
    logic [PERIOD_W-1:0] cfg_period;
    logic [FRAME_W-1:0]  cfg_start;
    logic [COUNT_W-1:0]  cfg_count;
    logic [COUNT_W-1:0]  cfg_fpr;
    logic [DIM_W-1:0]    cfg_width;
    logic [DIM_W-1:0]    cfg_height;

    frame_rec_t  frames_due [$];
    int unsigned errors;
    int unsigned n_ticks;
    int unsigned n_checked;
    int unsigned n_writes;
    int unsigned n_steps;
    bit          calm;
    int unsigned stall_left;

    function automatic logic [COORD_W-1:0] clip16(input int unsigned v);
        return (v > SAT_MAX) ? 16'hFFFF : v[COORD_W-1:0];
    endfunction

    function automatic frame_rec_t step_animation(input logic dir, input logic [TIME_W-1:0] dt);
        int unsigned period;
        int unsigned fpr;
        int unsigned steps;
        int unsigned seq_lo;
        int unsigned seq_hi;
        int unsigned len;
        int unsigned off;
        int unsigned k;
        int unsigned row;
        int unsigned col;
        int unsigned left;
        int unsigned top;
        frame_rec_t  r;
        period = (cfg_period == 0) ? 1 : cfg_period;
        fpr    = (cfg_fpr == 0) ? 1 : cfg_fpr;
        if (awaiting_first)
        begin
            acc_ticks      = '0;
            awaiting_first = 1'b0;
        end
        else
        begin
            acc_ticks = acc_ticks + dt;
        end
        if (acc_ticks >= period)
        begin
            steps     = acc_ticks / period;
            acc_ticks = ACC_W'(acc_ticks - steps * period);
            n_steps  += steps;
            seq_lo    = cfg_start;
            seq_hi    = cfg_start + ((cfg_count == 0) ? 1 : cfg_count) - 1;
            if (seq_hi > LAST_FRAME)
            begin
                seq_hi = LAST_FRAME;
            end
            // outside the sequence: snap to the first frame going forward or the last going back, costing one step
            if (cur_frame < seq_lo || cur_frame > seq_hi)
            begin
                cur_frame = FRAME_W'((dir == DIR_BACK) ? seq_hi : seq_lo);
                steps--;
            end
            len = seq_hi - seq_lo + 1;
            off = cur_frame - seq_lo;
            k   = steps % len;
            off = (dir == DIR_BACK) ? (off + len - k) % len : (off + k) % len;
            cur_frame = FRAME_W'(seq_lo + off);
        end
        row  = cur_frame / fpr;
        col  = cur_frame - row * fpr;
        left = col * cfg_width;
        top  = row * cfg_height;
        r.frame_index = cur_frame;
        r.src_left    = clip16(left);
        r.src_top     = clip16(top);
        r.src_right   = clip16(left + cfg_width);
        r.src_bottom  = clip16(top + cfg_height);
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] with_junk(input int unsigned v,
                                                        input int unsigned w);
        logic [CFG_DATA_W-1:0] keep;
        keep = CFG_DATA_W'((64'd1 << w) - 1);
        return (CFG_DATA_W'($urandom) & ~keep) | (CFG_DATA_W'(v) & keep);
    endfunction

    function automatic logic [TIME_W-1:0] pick_delta();
        int unsigned p;
        int unsigned v;
        p = (cfg_period == 0) ? 1 : cfg_period;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = SAT_MAX;
            2: v = 1;
            3, 4: v = $urandom_range(0, p - 1);
            5, 6:
            begin
                v = p * $urandom_range(1, 4);
                if (v > SAT_MAX)
                begin
                    v = SAT_MAX;
                end
            end
            default: v = $urandom_range(0, SAT_MAX);
        endcase
        return TIME_W'(v);
    endfunction

    function automatic bit field_ok(input string name, input int unsigned want,
                                    input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_PERIOD: cfg_period = data[PERIOD_W-1:0];
            REG_START:  cfg_start  = data[FRAME_W-1:0];
            REG_COUNT:  cfg_count  = data[COUNT_W-1:0];
            REG_FPR:    cfg_fpr    = data[COUNT_W-1:0];
            REG_WIDTH:  cfg_width  = data[DIM_W-1:0];
            REG_HEIGHT: cfg_height = data[DIM_W-1:0];
            default: ;
        endcase
        n_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // hold off new requests until every outstanding frame has come back
    task automatic settle_output();
        @(negedge clk);
        tick_ch.valid <= 1'b0;
        while (frames_due.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic new_settings();
        int unsigned v;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = SAT_MAX;
            2: v = $urandom_range(1, SAT_MAX);
            3: v = $urandom_range(100, 3000);
            default: v = $urandom_range(1, 6);
        endcase
        write_reg(REG_PERIOD, with_junk(v, PERIOD_W));
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = LAST_FRAME;
            2: v = $urandom_range(240, 254);
            default: v = $urandom_range(0, LAST_FRAME);
        endcase
        write_reg(REG_START, with_junk(v, FRAME_W));
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = 256;
            2: v = $urandom_range(1, 256);
            default: v = $urandom_range(1, 12);
        endcase
        write_reg(REG_COUNT, with_junk(v, COUNT_W));
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = 256;
            2: v = $urandom_range(1, 256);
            default: v = $urandom_range(1, 16);
        endcase
        write_reg(REG_FPR, with_junk(v, COUNT_W));
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = 4095;
            default: v = $urandom_range(0, 4095);
        endcase
        write_reg(REG_WIDTH, with_junk(v, DIM_W));
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = 4095;
            default: v = $urandom_range(0, 4095);
        endcase
        write_reg(REG_HEIGHT, with_junk(v, DIM_W));
        if ($urandom_range(0, 2) == 0)
        begin
            write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                      CFG_DATA_W'($urandom));
        end
    endtask

    task automatic send_tick(input logic dir, input logic [TIME_W-1:0] dt,
                             output frame_rec_t predicted);
        int unsigned gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            tick_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick_ch.op          <= dir;
        tick_ch.delta_ticks <= dt;
        tick_ch.valid       <= 1'b1;
        @(posedge clk);
        while (!tick_ch.ready)
        begin
            @(posedge clk);
        end
        predicted = step_animation(dir, dt);
        n_ticks++;
    endtask

    always #10 clk = ~clk;

    // result side stalls in bursts
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left     <= stall_left - 1;
            frame_ch.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left     <= $urandom_range(0, 12);
            frame_ch.ready <= 1'b0;
        end
        else
        begin
            frame_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_frames
        frame_rec_t got;
        frame_rec_t want;
        if (rst_n && frame_ch.valid && frame_ch.ready)
        begin
            got = '{frame_ch.frame_index, frame_ch.src_left, frame_ch.src_top,
                    frame_ch.src_right, frame_ch.src_bottom};
            if (frames_due.size() == 0)
            begin
                errors++;
                $display("%0t ns: frame with no request outstanding, expected none got %p",
                         $time, got);
            end
            else
            begin
                want = frames_due.pop_front();
                n_checked++;
                if (!(field_ok("frame_index", want.frame_index, got.frame_index)
                      & field_ok("src_left", want.src_left, got.src_left)
                      & field_ok("src_top", want.src_top, got.src_top)
                      & field_ok("src_right", want.src_right, got.src_right)
                      & field_ok("src_bottom", want.src_bottom, got.src_bottom)))
                begin
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #8_000_000;
        $display("tb: errors");
        $finish;
    end

    initial
    begin
        int unsigned i;
        int unsigned n_rand;
        int unsigned burst;
        int unsigned n_directed;
        frame_rec_t  predicted;

        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        tick_ch.valid        = 1'b0;
        tick_ch.op           = DIR_FWD;
        tick_ch.delta_ticks  = '0;
        frame_ch.ready       = 1'b0;
        stall_left           = 0;
        calm                 = 1'b0;
        errors               = 0;
        n_ticks              = 0;
        n_checked            = 0;
        n_writes             = 0;
        n_steps              = 0;
        acc_ticks            = '0;
        awaiting_first       = 1'b1;
        cur_frame            = '0;
        cfg_period           = 1;
        cfg_start            = 0;
        cfg_count            = 1;
        cfg_fpr              = 1;
        cfg_width            = 0;
        cfg_height           = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < PLAN_LEN; i++)
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                settle_output();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
            begin
                send_tick(plan[i].dir, plan[i].dt, predicted);
                frames_due.push_back(plan[i].typed ? plan[i].want : predicted);
            end
        end
        n_directed = n_ticks;

        n_rand = 0;
        while (n_rand < 560)
        begin
            settle_output();
            new_settings();
            calm  = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(15, 50);
            for (i = 0; i < burst; i++)
            begin
                if ($urandom_range(0, 39) == 0)
                begin
                    settle_output();
                end
                send_tick($urandom_range(0, 1), pick_delta(), predicted);
                frames_due.push_back(predicted);
            end
            n_rand += burst;
        end

        // closing stretch at full rate
        settle_output();
        new_settings();
        calm = 1'b1;
        for (i = 0; i < 40; i++)
        begin
            send_tick($urandom_range(0, 1), pick_delta(), predicted);
            frames_due.push_back(predicted);
        end

        settle_output();
        repeat (80) @(posedge clk);

        $display("summary: %0d tick requests (%0d directed), %0d frames checked",
                 n_ticks, n_directed, n_checked);
        $display("summary: %0d frame steps predicted, %0d register writes",
                 n_steps, n_writes);
        if (errors == 0)
        begin
            $display("tb: clean");
        end
        else
        begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/sfs_pkg.sv
src/sfs_if.sv
src/sfs_div.sv
src/sfs_cfg.sv
src/sprite_frame_sequencer.sv
tb/tb.sv
